[design/dvs_pkg.sv]
package dvs_pkg;

    // width of the value ports, fixed by the interface
    localparam int VALUE_PORT_W = 16;

    // sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PRIME,
        ST_CARRY,
        ST_SWEEP,
        ST_TAIL,
        ST_EMIT
    } dvs_state_t;

endpackage

[design/descending_value_sorter_unit.sv]
// Descending value sorter. Values arrive one per transaction on the s_ channel
// and are stored in a small on-chip RAM of MAX_COUNT entries; the transaction
// with s_last set closes the set. The block then bubble sorts the stored values
// in place and sends them back on the m_ channel largest first, with m_last_out
// on the final (smallest) value and m_overflow on every value of a set that
// brought more than MAX_COUNT values (the extra ones are dropped). Sorting a
// set uses a single comparator and the RAM's one write port: one
// compare-and-write per cycle in the sweep of each pass, which fetches the head
// entry, takes it as the carry, sweeps and writes the carry to the end of the
// range. Results then leave at one per cycle while m_ready is high. s_ready is
// low from the closing transaction until the last result is taken. Values are
// kept at min(VALUE_WIDTH, 16) bits.
module descending_value_sorter_unit #(
    parameter int MAX_COUNT   = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [dvs_pkg::VALUE_PORT_W-1:0] s_value,
    input  logic                             s_last,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [dvs_pkg::VALUE_PORT_W-1:0] m_sorted_value,
    output logic                             m_last_out,
    output logic                             m_overflow
);
    import dvs_pkg::*;

    localparam int STORE_W = (VALUE_WIDTH < VALUE_PORT_W) ? VALUE_WIDTH : VALUE_PORT_W;
    localparam int IDX_W   = $clog2(MAX_COUNT);
    localparam int CNT_W   = $clog2(MAX_COUNT + 1);

    // state and control registers
    dvs_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               overflow_reg, overflow_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   pass_end_reg, pass_end_next;
    logic               m_valid_reg, m_valid_next;
    logic [STORE_W-1:0] carry_reg, carry_next;

    // value store
    logic [STORE_W-1:0] mem [MAX_COUNT];
    logic [STORE_W-1:0] rd_data_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [STORE_W-1:0] wr_data;

    // handshake helpers
    logic in_xfer;
    logic out_xfer;
    logic store_full;
    logic last_result;
    logic sweep_done;

    assign in_xfer     = s_valid && s_ready;
    assign out_xfer    = m_valid_reg && m_ready;
    assign store_full  = (count_reg == CNT_W'(MAX_COUNT));
    assign last_result = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign sweep_done  = ((idx_reg + IDX_W'(1)) == pass_end_reg);

    // ports
    assign s_ready        = (state_reg == ST_LOAD);
    assign m_valid        = m_valid_reg;
    assign m_sorted_value = VALUE_PORT_W'(rd_data_reg);
    assign m_last_out     = last_result;
    assign m_overflow     = overflow_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_xfer && s_last) begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME: begin
                if (pass_end_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_CARRY;
                end
            end
            ST_CARRY: state_next = ST_SWEEP;
            ST_SWEEP: begin
                if (sweep_done) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: state_next = ST_PRIME;
            ST_EMIT: begin
                if (out_xfer && last_result) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // datapath control and shared compare unit
    always_comb begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        idx_next      = idx_reg;
        pass_end_next = pass_end_reg;
        m_valid_next  = m_valid_reg;
        carry_next    = carry_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = carry_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    // store while there is room, else drop and remember it
                    if (!store_full) begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        wr_data    = s_value[STORE_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                    // close the set: last index of the first pass
                    if (s_last) begin
                        if (store_full) begin
                            pass_end_next = IDX_W'(count_reg - CNT_W'(1));
                        end else begin
                            pass_end_next = count_reg[IDX_W-1:0];
                        end
                    end
                end
            end
            ST_PRIME: begin
                // fetch the head entry, for a new pass or for the first result
                rd_en    = 1'b1;
                rd_addr  = '0;
                idx_next = '0;
                if (pass_end_reg == '0) begin
                    m_valid_next = 1'b1;
                end
            end
            ST_CARRY: begin
                carry_next = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = idx_reg + IDX_W'(1);
            end
            ST_SWEEP: begin
                // larger value stays in front, smaller one travels on
                wr_en = 1'b1;
                if (carry_reg < rd_data_reg) begin
                    wr_data = rd_data_reg;
                end else begin
                    wr_data    = carry_reg;
                    carry_next = rd_data_reg;
                end
                if (!sweep_done) begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + IDX_W'(2);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_TAIL: begin
                // smallest of this pass lands at the end of the range
                wr_en         = 1'b1;
                wr_addr       = pass_end_reg;
                wr_data       = carry_reg;
                pass_end_next = pass_end_reg - IDX_W'(1);
            end
            ST_EMIT: begin
                if (out_xfer) begin
                    if (last_result) begin
                        m_valid_next  = 1'b0;
                        count_next    = '0;
                        overflow_next = 1'b0;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + IDX_W'(1);
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            idx_reg      <= '0;
            pass_end_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            idx_reg      <= idx_next;
            pass_end_reg <= pass_end_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // bubbling value
    always_ff @(posedge aclk) begin
        carry_reg <= carry_next;
    end

    // value store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_COUNT))
        else $error("fill count beyond capacity");

    a_sweep_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (idx_reg < pass_end_reg))
        else $error("sweep index past end of pass");

    a_valid_only_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == ST_EMIT))
        else $error("result valid outside emit phase");

    a_reload_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_out) |=> (s_ready && !m_valid && count_reg == '0))
        else $error("block not ready for a new set after final result");

endmodule

[tb/sv/descending_value_sorter_checker.sv]
`timescale 1ns / 1ps

module descending_value_sorter_checker #(
    parameter int MAX_COUNT   = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [dvs_pkg::VALUE_PORT_W-1:0] s_value,
    input  logic                             s_last,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [dvs_pkg::VALUE_PORT_W-1:0] m_sorted_value,
    input  logic                             m_last_out,
    input  logic                             m_overflow,
    output int                               mismatch_count,
    output int                               results_owed
);
    import dvs_pkg::*;

    typedef struct packed {
        logic [VALUE_PORT_W-1:0] value;
        logic                    last_out;
        logic                    overflow;
    } sorted_result_t;

    // the block keeps at most VALUE_WIDTH bits of each value
    localparam logic [VALUE_PORT_W-1:0] KEEP_MASK = (VALUE_WIDTH >= VALUE_PORT_W) ?
        {VALUE_PORT_W{1'b1}} : VALUE_PORT_W'((1 << VALUE_WIDTH) - 1);

    logic [VALUE_PORT_W-1:0] set_values [MAX_COUNT];
    int                      set_fill;
    bit                      set_dropped;
    sorted_result_t          owed_results [$];

    initial begin
        set_fill       = 0;
        set_dropped    = 1'b0;
    end

    // bubble sort the current set largest first and queue one result per value
    task automatic queue_sorted_set();
        logic [VALUE_PORT_W-1:0] work [MAX_COUNT];
        logic [VALUE_PORT_W-1:0] held;
        sorted_result_t          entry;
        work = set_values;
        for (int pass = 0; pass + 1 < set_fill; pass++) begin
            for (int k = 0; k + 1 < set_fill - pass; k++) begin
                if (work[k] < work[k + 1]) begin
                    held        = work[k];
                    work[k]     = work[k + 1];
                    work[k + 1] = held;
                end
            end
        end
        for (int k = 0; k < set_fill; k++) begin
            entry.value    = work[k];
            entry.last_out = (k + 1 == set_fill);
            entry.overflow = set_dropped;
            owed_results.push_back(entry);
        end
    endtask

    // watch both channels at every edge
    always @(posedge aclk) begin
        sorted_result_t want;
        int             misses;
        misses = 0;
        if (!aresetn) begin
            set_fill    = 0;
            set_dropped = 1'b0;
            owed_results.delete();
        end else begin
            // result transaction against the oldest prediction
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result with nothing owed: value %h last %b overflow %b",
                             $time, m_sorted_value, m_last_out, m_overflow);
                    misses++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_sorted_value !== want.value) begin
                        $display("%0t: sorted_value expected %h actual %h",
                                 $time, want.value, m_sorted_value);
                        misses++;
                    end
                    if (m_last_out !== want.last_out) begin
                        $display("%0t: last_out expected %b actual %b",
                                 $time, want.last_out, m_last_out);
                        misses++;
                    end
                    if (m_overflow !== want.overflow) begin
                        $display("%0t: overflow expected %b actual %b",
                                 $time, want.overflow, m_overflow);
                        misses++;
                    end
                end
            end
            // input transaction: store or drop, close the set on last
            if (s_valid && s_ready) begin
                if (set_fill < MAX_COUNT) begin
                    set_values[set_fill] = s_value & KEEP_MASK;
                    set_fill++;
                end else begin
                    set_dropped = 1'b1;
                end
                if (s_last) begin
                    queue_sorted_set();
                    set_fill    = 0;
                    set_dropped = 1'b0;
                end
            end
        end
        mismatch_count <= mismatch_count + misses;
        results_owed   <= owed_results.size();
    end

endmodule

[tb/sv/descending_value_sorter_unit_test.sv]
`timescale 1ns / 1ps

module descending_value_sorter_unit_test;
    import dvs_pkg::*;

    localparam int SORT_DEPTH   = 16;
    localparam int KEEP_WIDTH   = 16;
    localparam int RANDOM_ITEMS = 95;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic [VALUE_PORT_W-1:0] s_value        = '0;
    logic                    s_last         = 1'b0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic [VALUE_PORT_W-1:0] m_sorted_value;
    logic                    m_last_out;
    logic                    m_overflow;

    int mismatch_count;
    int results_owed;
    int items_sent  = 0;
    int drain_stall = 0;
    bit no_idle     = 1'b0;

    descending_value_sorter_unit #(
        .MAX_COUNT  (SORT_DEPTH),
        .VALUE_WIDTH(KEEP_WIDTH)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_last_out    (m_last_out),
        .m_overflow    (m_overflow)
    );

    descending_value_sorter_checker #(
        .MAX_COUNT  (SORT_DEPTH),
        .VALUE_WIDTH(KEEP_WIDTH)
    ) order_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_last_out    (m_last_out),
        .m_overflow    (m_overflow),
        .mismatch_count(mismatch_count),
        .results_owed  (results_owed)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // idle length: mostly short, now and then long
    function automatic int pause_cycles();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // value styles: full range, crowded (many equals), corners, near the top
    function automatic logic [VALUE_PORT_W-1:0] draw_value(int style);
        case (style)
            0: return VALUE_PORT_W'($urandom_range(0, 65535));
            1: return VALUE_PORT_W'($urandom_range(0, 3));
            2: begin
                case ($urandom_range(0, 3))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h8000;
                    default: return 16'h7FFF;
                endcase
            end
            default: return VALUE_PORT_W'($urandom_range(65530, 65535));
        endcase
    endfunction

    // result side stalls at random
    always @(posedge aclk) begin
        if (drain_stall > 0) begin
            drain_stall <= drain_stall - 1;
            m_ready     <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            drain_stall <= pause_cycles() - 1;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // one input transaction, with a random gap ahead of it
    task automatic push_value(input logic [VALUE_PORT_W-1:0] value, input bit closes);
        int gap;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pause_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        s_last  <= closes;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // hold the sender until every owed result has come back
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    // stimulus and verdict
    initial begin
        int set_len;
        int style;
        int random_goal;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single value set at the top of the range
        push_value(16'hFFFF, 1'b1);
        // two values at the extremes, smallest first
        push_value(16'h0000, 1'b0);
        push_value(16'hFFFF, 1'b1);
        // equal values
        for (int k = 0; k < 3; k++) push_value(16'h5A5A, k == 2);
        wait_for_drain();
        // ascending run past capacity, closing value is dropped
        for (int k = 0; k < SORT_DEPTH + 1; k++) begin
            push_value(VALUE_PORT_W'(k * 16'h0F0F), k == SORT_DEPTH);
        end
        wait_for_drain();

        // random sets, mostly small, some full and some overflowing
        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal) begin
            no_idle <= ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7,
                8, 9, 10, 11, 12, 13: set_len = $urandom_range(1, 6);
                14, 15, 16:           set_len = $urandom_range(7, SORT_DEPTH);
                17, 18:               set_len = SORT_DEPTH;
                default:              set_len = $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 4);
            endcase
            style = $urandom_range(0, 3);
            for (int k = 0; k < set_len; k++) push_value(draw_value(style), k == set_len - 1);
            if ($urandom_range(0, 5) == 0) wait_for_drain();
        end

        no_idle <= 1'b0;
        wait_for_drain();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
design/dvs_pkg.sv
design/descending_value_sorter_unit.sv
tb/sv/descending_value_sorter_checker.sv
tb/sv/descending_value_sorter_unit_test.sv
